// ===== design/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg
// Types, codes and hash functions shared by the station learning table.
// ----------------------------------------------------------------------------
package mlt_pkg;

    // Request codes
    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_LMAC    = 3'd1;
    localparam logic [2:0] REQ_LIP     = 3'd2;
    localparam logic [2:0] REQ_SWEEP   = 3'd3;
    localparam logic [2:0] REQ_INDEX   = 3'd4;
    localparam logic [2:0] REQ_UNINDEX = 3'd5;

    localparam logic [1:0]  STATUS_LEARNED  = 2'd2;
    localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;

    // Sequencer states; the datapath decodes them as micro-operations
    localparam logic [4:0] ST_CLEAR     = 5'd0;
    localparam logic [4:0] ST_IDLE      = 5'd1;
    localparam logic [4:0] ST_MF_HEAD   = 5'd2;
    localparam logic [4:0] ST_MF_HWAIT  = 5'd3;
    localparam logic [4:0] ST_MF_RD     = 5'd4;
    localparam logic [4:0] ST_MF_CMP    = 5'd5;
    localparam logic [4:0] ST_IX_HEAD   = 5'd6;
    localparam logic [4:0] ST_IX_LINK   = 5'd7;
    localparam logic [4:0] ST_IF_HEAD   = 5'd8;
    localparam logic [4:0] ST_UL_HEAD   = 5'd9;
    localparam logic [4:0] ST_IF_HWAIT  = 5'd10;
    localparam logic [4:0] ST_IF_RD     = 5'd11;
    localparam logic [4:0] ST_IF_CMP    = 5'd12;
    localparam logic [4:0] ST_UN_SPLICE = 5'd13;
    localparam logic [4:0] ST_UN_CLR    = 5'd14;
    localparam logic [4:0] ST_A_CHK     = 5'd15;
    localparam logic [4:0] ST_A_SLOT    = 5'd16;
    localparam logic [4:0] ST_A_STORE   = 5'd17;
    localparam logic [4:0] ST_SW_HEAD   = 5'd18;
    localparam logic [4:0] ST_SW_HWAIT  = 5'd19;
    localparam logic [4:0] ST_SW_RD     = 5'd20;
    localparam logic [4:0] ST_SW_CMP    = 5'd21;
    localparam logic [4:0] ST_SW_DEL    = 5'd22;
    localparam logic [4:0] ST_SW_FREE   = 5'd23;
    localparam logic [4:0] ST_SW_NEXTB  = 5'd24;
    localparam logic [4:0] ST_DONE      = 5'd25;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [47:0] mac_addr;
        logic [31:0] ip_addr;
        logic [1:0]  entry_status;
        logic [31:0] now_time;
        logic [31:0] age_timeout;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  found_status;
        logic [31:0] found_ip;
        logic [47:0] found_mac;
        logic [31:0] found_time;
        logic [10:0] entry_total;
        logic [10:0] removed_total;
        logic        table_changed;
        logic        dropped_full;
    } rsp_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [1:0]  status;
        logic [31:0] stamp;
    } rec_t;

    typedef struct packed {
        logic [4:0] uop;
        logic       load;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [2:0] req;
        logic       over_max;
        logic       full;
        logic       ip_zero;
        logic       cur_nil;
        logic       ip_nil;
        logic       mac_match;
        logic       ip_match;
        logic       idx;
        logic       age_rm;
        logic       ul;
        logic       node_idx;
        logic       last_bkt;
        logic       out_free;
    } stat_t;

    function automatic logic [11:0] mac_hash(input logic [47:0] m);
        logic [15:0] a;
        logic [7:0]  mid;
        a   = m[15:0] ^ m[47:32];
        mid = m[23:16] ^ m[31:24];
        return a[11:0] ^ {mid, a[15:12]};
    endfunction

    function automatic logic [11:0] ip_hash(input logic [31:0] ip);
        return ip[11:0] ^ ip[31:20];
    endfunction

endpackage

// ===== design/mac_ip_learning_table_top.sv =====
// Operation: lookups walk a hashed chain node by node; an add with a nonzero IP
//   also walks the IP chain; a sweep visits every bucket and every station, plus an
//   IP chain walk per indexed station removed. An add over the limit runs a sweep first.
// Throughput: one request at a time.
// Reset: synchronous, active low; a clearing pass empties the bucket heads and
//   refills the free list before s_ready rises.
// ----------------------------------------------------------------------------
// mac_ip_learning_table_top
// Station learning table with hashed MAC chains, IP index and aging sweep.
// ----------------------------------------------------------------------------
module mac_ip_learning_table_top #(
    parameter int BUCKETS = 4096,
    parameter int SLOTS   = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mlt_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mlt_pkg::rsp_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [10:0]    cfg_data
);
    import mlt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mlt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_req   (s_data.req_type),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mlt_dp #(
        .BUCKETS (BUCKETS),
        .SLOTS   (SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .stat      (stat)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a transaction while one is in progress");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.found_mac == 48'd0 && m_data.found_ip == 32'd0
                                   && m_data.found_time == 32'd0
                                   && m_data.found_status == 2'd0)
        else $error("found fields set without a hit");

    a_drop_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dropped_full |-> !m_data.hit)
        else $error("dropped add reports a hit");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid || m_ready)
        else $error("result overwritten before it was taken");

endmodule

// ===== design/mlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlt_ctrl
// Sequencer: walks the table operations step by step and commands the datapath.
// ----------------------------------------------------------------------------
module mlt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [2:0]      s_req,
    output logic            s_ready,
    input  mlt_pkg::stat_t  stat,
    output mlt_pkg::cmd_t   cmd
);
    import mlt_pkg::*;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req)
                        REQ_ADD:                state_next = stat.over_max ? ST_SW_HEAD
                                                                           : ST_A_CHK;
                        REQ_LMAC, REQ_INDEX:    state_next = ST_MF_HEAD;
                        REQ_LIP, REQ_UNINDEX:   state_next = ST_IF_HEAD;
                        REQ_SWEEP:              state_next = ST_SW_HEAD;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_MF_HEAD:  state_next = ST_MF_HWAIT;
            ST_MF_HWAIT: state_next = ST_MF_RD;
            ST_MF_RD:    state_next = stat.cur_nil ? ST_DONE : ST_MF_CMP;
            ST_MF_CMP: begin
                if (!stat.mac_match) state_next = ST_MF_RD;
                else if (stat.req == REQ_INDEX && !stat.idx) state_next = ST_IX_HEAD;
                else state_next = ST_DONE;
            end
            ST_IX_HEAD:  state_next = ST_IX_LINK;
            ST_IX_LINK:  state_next = ST_DONE;
            ST_IF_HEAD, ST_UL_HEAD: state_next = ST_IF_HWAIT;
            ST_IF_HWAIT: state_next = ST_IF_RD;
            ST_IF_RD: begin
                if (!stat.ip_nil) state_next = ST_IF_CMP;
                else if (stat.ul) state_next = ST_UN_CLR;
                else if (stat.req == REQ_ADD) state_next = ST_A_STORE;
                else state_next = ST_DONE;
            end
            ST_IF_CMP: begin
                if (!stat.ip_match) state_next = ST_IF_RD;
                else if (stat.ul || stat.req == REQ_UNINDEX) state_next = ST_UN_SPLICE;
                else if (stat.req == REQ_ADD) state_next = ST_A_STORE;
                else state_next = ST_DONE;
            end
            ST_UN_SPLICE: state_next = ST_UN_CLR;
            ST_UN_CLR:    state_next = stat.ul ? ST_SW_FREE : ST_DONE;
            ST_A_CHK:     state_next = stat.full ? ST_DONE : ST_A_SLOT;
            ST_A_SLOT:    state_next = stat.ip_zero ? ST_A_STORE : ST_IF_HEAD;
            ST_A_STORE:   state_next = ST_DONE;
            ST_SW_HEAD:   state_next = ST_SW_HWAIT;
            ST_SW_HWAIT:  state_next = ST_SW_RD;
            ST_SW_RD:     state_next = stat.cur_nil ? ST_SW_NEXTB : ST_SW_CMP;
            ST_SW_CMP:    state_next = stat.age_rm ? ST_SW_DEL : ST_SW_RD;
            ST_SW_DEL:    state_next = stat.node_idx ? ST_UL_HEAD : ST_SW_FREE;
            ST_SW_FREE:   state_next = ST_SW_RD;
            ST_SW_NEXTB: begin
                if (!stat.last_bkt) state_next = ST_SW_HEAD;
                else if (stat.req == REQ_ADD) state_next = ST_A_CHK;
                else state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.uop      = state_reg;
    assign cmd.load     = s_valid && s_ready;
    assign cmd.out_load = (state_reg == ST_DONE) && stat.out_free;

endmodule

// ===== design/mlt_dp.sv =====
// ----------------------------------------------------------------------------
// mlt_dp
// Datapath: slot, link, bucket and free-list memories, walk registers, result.
// ----------------------------------------------------------------------------
module mlt_dp #(
    parameter int BUCKETS = 4096,
    parameter int SLOTS   = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  mlt_pkg::cmd_t   cmd,
    input  mlt_pkg::req_t   s_data,
    input  logic            cfg_valid,
    input  logic [10:0]     cfg_data,
    input  logic            m_ready,
    output logic            m_valid,
    output mlt_pkg::rsp_t   m_data,
    output mlt_pkg::stat_t  stat
);
    import mlt_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int BW = $clog2(BUCKETS);
    localparam int CN = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
    localparam int CW = $clog2(CN);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    // Memories
    rec_t          rec_mem    [SLOTS];
    logic [LW-1:0] mlink_mem  [SLOTS];
    logic [LW-1:0] iplink_mem [SLOTS];
    logic          idx_mem    [SLOTS];
    logic [SW-1:0] free_mem   [SLOTS];
    logic [LW-1:0] mhead_mem  [BUCKETS];
    logic [LW-1:0] iphead_mem [BUCKETS];

    rec_t          rec_rd_reg;
    logic [LW-1:0] mlink_rd_reg, iplink_rd_reg, mhead_rd_reg, iphead_rd_reg;
    logic          idx_rd_reg;
    logic [SW-1:0] free_rd_reg;

    // State and walk registers
    req_t          req_reg;
    logic [31:0]   timeout_reg;
    logic [10:0]   max_reg;
    logic [LW-1:0] used_reg, count_reg;
    logic          dropped_reg, hit_reg;
    rec_t          found_reg;
    logic [LW-1:0] m_cur_reg, m_prev_reg, m_nxt_reg;
    logic [LW-1:0] ip_cur_reg, ip_prev_reg, ip_nxt_reg, ip_head_reg, mhead_cap_reg;
    logic          ip_found_reg, ul_reg, node_idx_reg;
    logic [31:0]   node_ip_reg;
    logic [BW-1:0] ip_bkt_reg, bkt_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] clr_reg;
    logic          m_valid_reg;
    rsp_t          m_data_reg;

    logic [BW-1:0] mac_bkt, ipin_bkt, node_bkt, found_bkt;
    logic          add_link;
    logic [LW-1:0] free_pop_idx, free_push_idx;

    assign mac_bkt   = BW'(32'(mac_hash(req_reg.mac_addr)) % BUCKETS);
    assign ipin_bkt  = BW'(32'(ip_hash(req_reg.ip_addr)) % BUCKETS);
    assign node_bkt  = BW'(32'(ip_hash(node_ip_reg)) % BUCKETS);
    assign found_bkt = BW'(32'(ip_hash(found_reg.ip)) % BUCKETS);
    assign add_link  = (req_reg.ip_addr != 32'd0) && !ip_found_reg;
    assign free_pop_idx  = NIL - LW'(1) - used_reg;
    assign free_push_idx = NIL - used_reg;

    // Memory port controls
    logic          rec_re, rec_we, mlink_re, mlink_we, iplink_re, iplink_we;
    logic          idx_re, idx_we, idx_wd, free_re, free_we;
    logic          mhead_re, mhead_we, iphead_re, iphead_we;
    logic [SW-1:0] rec_ra, slot_ra, iplink_ra, mlink_wa, iplink_wa, idx_wa, free_wa;
    logic [SW-1:0] free_wd;
    logic [BW-1:0] mhead_ra, mhead_wa, iphead_ra, iphead_wa;
    logic [LW-1:0] mlink_wd, iplink_wd, mhead_wd, iphead_wd;

    always_comb begin
        rec_re    = 1'b0;  rec_we    = 1'b0;
        mlink_re  = 1'b0;  mlink_we  = 1'b0;
        iplink_re = 1'b0;  iplink_we = 1'b0;
        idx_re    = 1'b0;  idx_we    = 1'b0;  idx_wd = 1'b0;
        free_re   = 1'b0;  free_we   = 1'b0;
        mhead_re  = 1'b0;  mhead_we  = 1'b0;
        iphead_re = 1'b0;  iphead_we = 1'b0;
        rec_ra    = m_cur_reg[SW-1:0];
        slot_ra   = m_cur_reg[SW-1:0];
        iplink_ra = ip_cur_reg[SW-1:0];
        mlink_wa  = slot_reg;      mlink_wd  = mhead_cap_reg;
        iplink_wa = slot_reg;      iplink_wd = NIL;
        idx_wa    = slot_reg;
        free_wa   = free_push_idx[SW-1:0];
        free_wd   = m_cur_reg[SW-1:0];
        mhead_ra  = mac_bkt;       mhead_wa  = mac_bkt;   mhead_wd  = NIL;
        iphead_ra = ipin_bkt;      iphead_wa = ip_bkt_reg; iphead_wd = NIL;
        case (cmd.uop)
            ST_CLEAR: begin
                mhead_we  = (32'(clr_reg) < BUCKETS);
                iphead_we = (32'(clr_reg) < BUCKETS);
                mhead_wa  = clr_reg[BW-1:0];
                iphead_wa = clr_reg[BW-1:0];
                free_we   = (32'(clr_reg) < SLOTS);
                free_wa   = clr_reg[SW-1:0];
                free_wd   = SW'(SLOTS - 1) - clr_reg[SW-1:0];
            end
            ST_MF_HEAD: mhead_re = 1'b1;
            ST_MF_RD, ST_SW_RD: begin
                rec_re   = 1'b1;
                mlink_re = 1'b1;
                idx_re   = 1'b1;
            end
            ST_IX_HEAD: begin
                iphead_re = 1'b1;
                iphead_ra = found_bkt;
            end
            ST_IX_LINK: begin
                iplink_we = 1'b1;
                iplink_wa = m_cur_reg[SW-1:0];
                iplink_wd = iphead_rd_reg;
                iphead_we = 1'b1;
                iphead_wd = m_cur_reg;
                idx_we    = 1'b1;
                idx_wa    = m_cur_reg[SW-1:0];
                idx_wd    = 1'b1;
            end
            ST_IF_HEAD: iphead_re = 1'b1;
            ST_UL_HEAD: begin
                iphead_re = 1'b1;
                iphead_ra = node_bkt;
            end
            ST_IF_RD: begin
                rec_re    = 1'b1;
                rec_ra    = ip_cur_reg[SW-1:0];
                iplink_re = 1'b1;
            end
            ST_UN_SPLICE: begin
                // unlink from the bucket head or from the predecessor
                if (ip_prev_reg == NIL) begin
                    iphead_we = 1'b1;
                    iphead_wd = ip_nxt_reg;
                end else begin
                    iplink_we = 1'b1;
                    iplink_wa = ip_prev_reg[SW-1:0];
                    iplink_wd = ip_nxt_reg;
                end
            end
            ST_UN_CLR: begin
                iplink_we = 1'b1;
                iplink_wa = ul_reg ? m_cur_reg[SW-1:0] : ip_cur_reg[SW-1:0];
                idx_we    = 1'b1;
                idx_wa    = ul_reg ? m_cur_reg[SW-1:0] : ip_cur_reg[SW-1:0];
            end
            ST_A_CHK: begin
                mhead_re = 1'b1;
                free_re  = 1'b1;
            end
            ST_A_STORE: begin
                rec_we    = 1'b1;
                mlink_we  = 1'b1;
                mhead_we  = 1'b1;
                mhead_wd  = LW'(slot_reg);
                iplink_we = 1'b1;
                iplink_wd = add_link ? ip_head_reg : NIL;
                idx_we    = 1'b1;
                idx_wd    = add_link;
                iphead_we = add_link;
                iphead_wd = LW'(slot_reg);
            end
            ST_SW_HEAD: begin
                mhead_re = 1'b1;
                mhead_ra = bkt_reg;
            end
            ST_SW_DEL: begin
                if (m_prev_reg == NIL) begin
                    mhead_we = 1'b1;
                    mhead_wa = bkt_reg;
                    mhead_wd = m_nxt_reg;
                end else begin
                    mlink_we = 1'b1;
                    mlink_wa = m_prev_reg[SW-1:0];
                    mlink_wd = m_nxt_reg;
                end
            end
            ST_SW_FREE: free_we = (used_reg != '0);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rec_we) rec_mem[slot_reg] <= '{mac: req_reg.mac_addr, ip: req_reg.ip_addr,
                                           status: req_reg.entry_status,
                                           stamp: req_reg.now_time};
        if (rec_re) rec_rd_reg <= rec_mem[rec_ra];
    end

    always_ff @(posedge aclk) begin
        if (mlink_we) mlink_mem[mlink_wa] <= mlink_wd;
        if (mlink_re) mlink_rd_reg <= mlink_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (iplink_we) iplink_mem[iplink_wa] <= iplink_wd;
        if (iplink_re) iplink_rd_reg <= iplink_mem[iplink_ra];
    end

    always_ff @(posedge aclk) begin
        if (idx_we) idx_mem[idx_wa] <= idx_wd;
        if (idx_re) idx_rd_reg <= idx_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (free_we) free_mem[free_wa] <= free_wd;
        if (free_re) free_rd_reg <= free_mem[free_pop_idx[SW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (mhead_we) mhead_mem[mhead_wa] <= mhead_wd;
        if (mhead_re) mhead_rd_reg <= mhead_mem[mhead_ra];
    end

    always_ff @(posedge aclk) begin
        if (iphead_we) iphead_mem[iphead_wa] <= iphead_wd;
        if (iphead_re) iphead_rd_reg <= iphead_mem[iphead_ra];
    end

    // Status toward the sequencer
    always_comb begin
        stat.clr_done  = (clr_reg == CW'(CN - 1));
        stat.req       = req_reg.req_type;
        stat.over_max  = (32'(used_reg) >= 32'(max_reg));
        stat.full      = (used_reg >= NIL);
        stat.ip_zero   = (req_reg.ip_addr == 32'd0);
        stat.cur_nil   = (m_cur_reg == NIL);
        stat.ip_nil    = (ip_cur_reg == NIL);
        stat.mac_match = (rec_rd_reg.mac == req_reg.mac_addr);
        stat.ip_match  = ul_reg ? (ip_cur_reg == m_cur_reg)
                                : (rec_rd_reg.ip == req_reg.ip_addr);
        stat.idx       = idx_rd_reg;
        stat.age_rm    = (rec_rd_reg.status == STATUS_LEARNED) &&
                         ((req_reg.now_time - rec_rd_reg.stamp) >= timeout_reg);
        stat.ul        = ul_reg;
        stat.node_idx  = node_idx_reg;
        stat.last_bkt  = (bkt_reg == BW'(BUCKETS - 1));
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            used_reg    <= '0;
            max_reg     <= MAX_ENTRIES_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.uop == ST_CLEAR) clr_reg <= clr_reg + CW'(1);
            if (cfg_valid) max_reg <= cfg_data;
            if (cmd.uop == ST_A_STORE) used_reg <= used_reg + LW'(1);
            else if (cmd.uop == ST_SW_FREE && used_reg != '0) used_reg <= used_reg - LW'(1);
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Walk and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= s_data;
            timeout_reg <= (s_data.req_type == REQ_ADD) ? 32'd0 : s_data.age_timeout;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            hit_reg     <= 1'b0;
            found_reg   <= '0;
            bkt_reg     <= '0;
            ul_reg      <= 1'b0;
        end
        case (cmd.uop)
            ST_MF_HWAIT, ST_SW_HWAIT: begin
                m_cur_reg  <= mhead_rd_reg;
                m_prev_reg <= NIL;
            end
            ST_MF_CMP: begin
                if (stat.mac_match) begin
                    hit_reg   <= 1'b1;
                    found_reg <= rec_rd_reg;
                end else begin
                    m_cur_reg <= mlink_rd_reg;
                end
            end
            ST_IX_HEAD: ip_bkt_reg <= found_bkt;
            ST_IF_HEAD: begin
                ip_bkt_reg   <= ipin_bkt;
                ul_reg       <= 1'b0;
                ip_found_reg <= 1'b0;
            end
            ST_UL_HEAD: begin
                ip_bkt_reg   <= node_bkt;
                ul_reg       <= 1'b1;
                ip_found_reg <= 1'b0;
            end
            ST_IF_HWAIT: begin
                ip_cur_reg  <= iphead_rd_reg;
                ip_head_reg <= iphead_rd_reg;
                ip_prev_reg <= NIL;
            end
            ST_IF_CMP: begin
                ip_nxt_reg <= iplink_rd_reg;
                if (stat.ip_match) begin
                    ip_found_reg <= 1'b1;
                    // report only for lookups and unindex
                    if (!ul_reg && req_reg.req_type != REQ_ADD) begin
                        hit_reg   <= 1'b1;
                        found_reg <= rec_rd_reg;
                    end
                end else begin
                    ip_prev_reg <= ip_cur_reg;
                    ip_cur_reg  <= iplink_rd_reg;
                end
            end
            ST_A_CHK: dropped_reg <= stat.full;
            ST_A_SLOT: begin
                slot_reg      <= free_rd_reg;
                mhead_cap_reg <= mhead_rd_reg;
            end
            ST_SW_CMP: begin
                m_nxt_reg    <= mlink_rd_reg;
                node_ip_reg  <= rec_rd_reg.ip;
                node_idx_reg <= idx_rd_reg;
                if (!stat.age_rm) begin
                    m_prev_reg <= m_cur_reg;
                    m_cur_reg  <= mlink_rd_reg;
                end
            end
            ST_SW_FREE: begin
                count_reg <= count_reg + LW'(1);
                m_cur_reg <= m_nxt_reg;
            end
            ST_SW_NEXTB: bkt_reg <= bkt_reg + BW'(1);
            default: ;
        endcase
        if (cmd.out_load) begin
            m_data_reg.hit           <= hit_reg;
            m_data_reg.found_status  <= found_reg.status;
            m_data_reg.found_ip      <= found_reg.ip;
            m_data_reg.found_mac     <= found_reg.mac;
            m_data_reg.found_time    <= found_reg.stamp;
            m_data_reg.entry_total   <= 11'(used_reg);
            m_data_reg.removed_total <= 11'(count_reg);
            m_data_reg.table_changed <= (count_reg != '0);
            m_data_reg.dropped_full  <= dropped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/sv/mac_ip_learning_table_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mac_ip_learning_table_top_test
// Self-checking bench for the station learning table. A queue-fed driver
// sends requests; a behavioral table model predicts each response, and a
// monitor compares every response field against the oldest prediction.
// Phases move the entry limit through 1, mid values and 1024, ending with
// a table fill that forces dropped adds.
// ----------------------------------------------------------------------------
module mac_ip_learning_table_top_test;
    import mlt_pkg::*;

    localparam int NBKT = 4096;
    localparam int NSLOT = 1024;
    localparam int NIL = NSLOT;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam logic [1:0] ST_ALLOW = 2'd0;
    localparam logic [1:0] ST_DENY = 2'd1;
    localparam logic [1:0] ST_OTHER = 2'd3;
    localparam int WDOG_LIMIT = 200000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    req_t        s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    rsp_t        m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    mac_ip_learning_table_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // table model state
    logic [47:0] tbl_mac [NSLOT];
    logic [31:0] tbl_ip [NSLOT];
    logic [1:0]  tbl_stat [NSLOT];
    logic [31:0] tbl_time [NSLOT];
    int          tbl_mlink [NSLOT];
    int          tbl_ilink [NSLOT];
    bit          tbl_indexed [NSLOT];
    int          mac_head [NBKT];
    int          ip_head [NBKT];
    int          free_list [NSLOT];
    int          used_n;
    int          entry_limit;

    req_t        pend_q[$];
    rsp_t        rsp_q[$];
    logic [47:0] mac_pool[$];
    logic [31:0] ip_pool[$];
    int          errors = 0;
    int          sent_cnt = 0;
    int          wdog = 0;
    logic [31:0] tnow = 32'd5000;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int mac_bucket(logic [47:0] m);
        logic [31:0] a, mid, b;
        a = {16'd0, m[15:0] ^ m[47:32]};
        mid = {24'd0, m[23:16] ^ m[31:24]};
        b = a + (mid << 16);
        return int'((a ^ (b >> 12)) & 32'hfff);
    endfunction

    function automatic int ip_bucket(logic [31:0] ip);
        return int'(((ip & 32'hfff) ^ (ip >> 20)) & 32'hfff);
    endfunction

    function automatic int find_by_mac(logic [47:0] m);
        int cur;
        cur = mac_head[mac_bucket(m)];
        while (cur != NIL) begin
            if (tbl_mac[cur] == m) return cur;
            cur = tbl_mlink[cur];
        end
        return NIL;
    endfunction

    function automatic int find_by_ip(logic [31:0] ip);
        int cur;
        cur = ip_head[ip_bucket(ip)];
        while (cur != NIL) begin
            if (tbl_ip[cur] == ip) return cur;
            cur = tbl_ilink[cur];
        end
        return NIL;
    endfunction

    function automatic void ip_unlink(int s);
        int b, prev, cur;
        b = ip_bucket(tbl_ip[s]);
        prev = NIL;
        cur = ip_head[b];
        while (cur != NIL) begin
            if (cur == s) begin
                if (prev == NIL) ip_head[b] = tbl_ilink[cur];
                else tbl_ilink[prev] = tbl_ilink[cur];
                break;
            end
            prev = cur;
            cur = tbl_ilink[cur];
        end
        tbl_ilink[s] = NIL;
        tbl_indexed[s] = 0;
    endfunction

    function automatic void ip_link(int s);
        int b;
        b = ip_bucket(tbl_ip[s]);
        tbl_ilink[s] = ip_head[b];
        ip_head[b] = s;
        tbl_indexed[s] = 1;
    endfunction

    function automatic int age_out(logic [31:0] now, logic [31:0] tmo);
        int prev, cur, nxt, cnt;
        cnt = 0;
        for (int b = 0; b < NBKT; b++) begin
            prev = NIL;
            cur = mac_head[b];
            while (cur != NIL) begin
                nxt = tbl_mlink[cur];
                if (tbl_stat[cur] == STATUS_LEARNED && (now - tbl_time[cur]) >= tmo) begin
                    if (prev == NIL) mac_head[b] = nxt;
                    else tbl_mlink[prev] = nxt;
                    if (tbl_indexed[cur]) ip_unlink(cur);
                    if (used_n > 0) begin
                        used_n--;
                        free_list[NSLOT - 1 - used_n] = cur;
                    end
                    cnt++;
                end else begin
                    prev = cur;
                end
                cur = nxt;
            end
        end
        return cnt;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_mlink[i] = NIL;
            tbl_ilink[i] = NIL;
            tbl_indexed[i] = 0;
            free_list[i] = NSLOT - 1 - i;
        end
        for (int i = 0; i < NBKT; i++) begin
            mac_head[i] = NIL;
            ip_head[i] = NIL;
        end
        used_n = 0;
        entry_limit = 1024;
    endfunction

    function automatic void fill_found(inout rsp_t r, input int s);
        r.hit = 1;
        r.found_status = tbl_stat[s];
        r.found_ip = tbl_ip[s];
        r.found_mac = tbl_mac[s];
        r.found_time = tbl_time[s];
    endfunction

    function automatic rsp_t table_apply(req_t q);
        rsp_t r;
        int s, removed, b;
        r = '0;
        removed = 0;
        case (q.req_type)
            REQ_ADD: begin
                if (used_n >= entry_limit) removed = age_out(q.now_time, 32'd0);
                if (used_n >= NSLOT) begin
                    r.dropped_full = 1;
                end else begin
                    s = free_list[NSLOT - 1 - used_n];
                    used_n++;
                    tbl_mac[s] = q.mac_addr;
                    tbl_ip[s] = q.ip_addr;
                    tbl_stat[s] = q.entry_status;
                    tbl_time[s] = q.now_time;
                    tbl_indexed[s] = 0;
                    tbl_ilink[s] = NIL;
                    b = mac_bucket(q.mac_addr);
                    tbl_mlink[s] = mac_head[b];
                    mac_head[b] = s;
                    if (q.ip_addr != 0 && find_by_ip(q.ip_addr) == NIL) ip_link(s);
                end
            end
            REQ_LMAC: begin
                s = find_by_mac(q.mac_addr);
                if (s != NIL) fill_found(r, s);
            end
            REQ_LIP: begin
                s = find_by_ip(q.ip_addr);
                if (s != NIL) fill_found(r, s);
            end
            REQ_SWEEP: removed = age_out(q.now_time, q.age_timeout);
            REQ_INDEX: begin
                s = find_by_mac(q.mac_addr);
                if (s != NIL) begin
                    if (!tbl_indexed[s]) ip_link(s);
                    fill_found(r, s);
                end
            end
            REQ_UNINDEX: begin
                s = find_by_ip(q.ip_addr);
                if (s != NIL) begin
                    fill_found(r, s);
                    ip_unlink(s);
                end
            end
            default: ;
        endcase
        r.entry_total = 11'(used_n);
        r.removed_total = 11'(removed);
        r.table_changed = (removed != 0);
        return r;
    endfunction

    task automatic report_mismatch(string fld, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, fld, got, want);
    endtask

    task automatic compare_rsp(rsp_t got, rsp_t want);
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.found_status !== want.found_status)
            report_mismatch("found_status", got.found_status, want.found_status);
        if (got.found_ip !== want.found_ip) report_mismatch("found_ip", got.found_ip, want.found_ip);
        if (got.found_mac !== want.found_mac)
            report_mismatch("found_mac", got.found_mac, want.found_mac);
        if (got.found_time !== want.found_time)
            report_mismatch("found_time", got.found_time, want.found_time);
        if (got.entry_total !== want.entry_total)
            report_mismatch("entry_total", got.entry_total, want.entry_total);
        if (got.removed_total !== want.removed_total)
            report_mismatch("removed_total", got.removed_total, want.removed_total);
        if (got.table_changed !== want.table_changed)
            report_mismatch("table_changed", got.table_changed, want.table_changed);
        if (got.dropped_full !== want.dropped_full)
            report_mismatch("dropped_full", got.dropped_full, want.dropped_full);
    endtask

    function automatic bit steady_window();
        return sent_cnt >= 400 && sent_cnt < 700;
    endfunction

    // request driver; predicts at the accepting edge
    always @(posedge aclk) begin
        logic go;
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) begin
                rsp_q.push_back(table_apply(s_data));
                sent_cnt++;
            end
            if (!s_valid || s_ready) begin
                go = pend_q.size() > 0 && (steady_window() || $urandom_range(99) >= 26);
                if (go) begin
                    s_data <= pend_q.pop_front();
                    s_valid <= 1;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // response monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (rsp_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected response transaction", $realtime);
                end else begin
                    compare_rsp(m_data, rsp_q.pop_front());
                end
            end
            m_ready <= steady_window() || $urandom_range(99) >= 26;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_req(logic [2:0] t, logic [47:0] m, logic [31:0] ip,
                            logic [1:0] st, logic [31:0] now, logic [31:0] tmo);
        req_t q;
        q.req_type = t;
        q.mac_addr = m;
        q.ip_addr = ip;
        q.entry_status = st;
        q.now_time = now;
        q.age_timeout = tmo;
        pend_q.push_back(q);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pend_q.size() != 0 || s_valid || rsp_q.size() != 0);
    endtask

    task automatic write_limit(logic [10:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        entry_limit = v;
        cfg_valid <= 0;
    endtask

    // fresh MAC; some share a bucket on purpose to grow chains
    function automatic logic [47:0] fresh_mac();
        logic [47:0] m;
        logic [15:0] a, lo;
        logic [7:0]  mid, o2;
        if ($urandom_range(99) < 30) begin
            a = $urandom_range(1) ? 16'h1234 : 16'hbeef;
            mid = $urandom_range(1) ? 8'h5a : 8'h00;
            lo = 16'($urandom);
            o2 = 8'($urandom);
            m = {lo ^ a, o2 ^ mid, o2, lo};
        end else begin
            m = {16'($urandom), 32'($urandom)};
        end
        mac_pool.push_back(m);
        if (mac_pool.size() > 64) void'(mac_pool.pop_front());
        return m;
    endfunction

    function automatic logic [31:0] fresh_ip();
        logic [31:0] ip;
        logic [11:0] hi;
        if ($urandom_range(99) < 15) return 32'd0;
        if ($urandom_range(99) < 30) begin
            hi = 12'($urandom);
            ip = {hi, 8'($urandom), hi ^ 12'h3c5};
        end else begin
            ip = $urandom;
        end
        ip_pool.push_back(ip);
        if (ip_pool.size() > 64) void'(ip_pool.pop_front());
        return ip;
    endfunction

    function automatic logic [47:0] known_mac();
        if (mac_pool.size() == 0 || $urandom_range(99) < 15) return {16'($urandom), 32'($urandom)};
        return mac_pool[$urandom_range(mac_pool.size() - 1)];
    endfunction

    function automatic logic [31:0] known_ip();
        if (ip_pool.size() == 0 || $urandom_range(99) < 15) return $urandom;
        return ip_pool[$urandom_range(ip_pool.size() - 1)];
    endfunction

    function automatic logic [31:0] stamp();
        tnow += $urandom_range(5);
        return ($urandom_range(99) < 10) ? $urandom : tnow;
    endfunction

    task automatic random_mix(int n, int learned_pct);
        int k;
        logic [1:0] st;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            st = ($urandom_range(99) < learned_pct) ? STATUS_LEARNED : 2'($urandom);
            if (k < 35)
                push_req(REQ_ADD, ($urandom_range(9) == 0) ? known_mac() : fresh_mac(),
                         fresh_ip(), st, stamp(), $urandom);
            else if (k < 60) push_req(REQ_LMAC, known_mac(), $urandom, 2'($urandom), stamp(), $urandom);
            else if (k < 75) push_req(REQ_LIP, known_ip(), 0, 2'($urandom), stamp(), $urandom);
            else if (k < 85)
                push_req(REQ_INDEX, known_mac(), $urandom, 2'($urandom), stamp(), $urandom);
            else if (k < 95)
                push_req(REQ_UNINDEX, known_mac(), known_ip(), 2'($urandom), stamp(), $urandom);
            else if (k < 97)
                push_req(REQ_SWEEP, $urandom, $urandom, 2'($urandom), stamp(),
                         ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(150)));
            else
                push_req($urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7, known_mac(), known_ip(),
                         2'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [47:0] ma, mb, mc;
        logic [31:0] ipx, ipy;
        int fill_n;
        table_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        ma = 48'h0000_1122_3344;
        mb = 48'h0a0b_0c0d_0e0f;
        mc = 48'h8000_0000_0001;
        ipx = 32'hc0a8_0101;
        ipy = 32'h0a00_0002;
        push_req(REQ_LMAC, 48'd0, 0, ST_ALLOW, 0, 0);
        push_req(REQ_LIP, 0, 32'd0, ST_ALLOW, 0, 0);
        push_req(REQ_UNINDEX, 0, ipx, ST_ALLOW, 0, 0);
        push_req(REQ_INDEX, ma, 0, ST_ALLOW, 0, 0);
        push_req(REQ_SWEEP, 0, 0, ST_ALLOW, 0, 0);
        push_req(REQ_SPARE6, ma, ipx, ST_OTHER, 1, 1);
        push_req(REQ_SPARE7, ma, ipx, ST_OTHER, 1, 1);
        push_req(REQ_ADD, ma, ipx, STATUS_LEARNED, 100, 0);
        push_req(REQ_ADD, mb, 32'd0, ST_ALLOW, 101, 0);
        push_req(REQ_ADD, mc, ipx, ST_OTHER, 102, 0);
        push_req(REQ_ADD, ma, ipy, ST_DENY, 103, 0);
        push_req(REQ_ADD, '1, '1, ST_OTHER, '1, '1);
        push_req(REQ_LMAC, ma, 0, ST_ALLOW, 0, 0);
        push_req(REQ_LIP, 0, ipx, ST_ALLOW, 0, 0);
        push_req(REQ_LIP, 0, '1, ST_ALLOW, 0, 0);
        push_req(REQ_INDEX, mc, 0, ST_ALLOW, 0, 0);
        push_req(REQ_LIP, 0, ipx, ST_ALLOW, 0, 0);
        push_req(REQ_INDEX, mb, 0, ST_ALLOW, 0, 0);
        push_req(REQ_INDEX, mc, 0, ST_ALLOW, 0, 0);
        push_req(REQ_UNINDEX, 0, ipx, ST_ALLOW, 0, 0);
        push_req(REQ_LIP, 0, ipx, ST_ALLOW, 0, 0);
        push_req(REQ_LIP, 0, 32'd0, ST_ALLOW, 0, 0);
        push_req(REQ_SWEEP, 0, 0, ST_ALLOW, 200, 200);
        push_req(REQ_SWEEP, 0, 0, ST_ALLOW, 200, 0);
        push_req(REQ_LIP, 0, ipx, ST_ALLOW, 0, 0);
        wait_drained();

        // every add now flushes the learned stations first
        write_limit(11'd1);
        for (int i = 0; i < 4; i++) begin
            push_req(REQ_ADD, fresh_mac(), fresh_ip(), STATUS_LEARNED, stamp(), 0);
            push_req(REQ_LMAC, known_mac(), 0, ST_ALLOW, 0, 0);
        end
        wait_drained();

        write_limit(11'd60);
        random_mix(400, 90);
        wait_drained();
        write_limit(11'd300);
        random_mix(400, 90);
        push_req(REQ_SWEEP, 0, 0, ST_ALLOW, tnow, 0);
        wait_drained();

        // fill the table with stations that never age, then overflow it
        write_limit(11'd1024);
        fill_n = NSLOT - used_n + 3;
        while (fill_n > 0) begin
            if ($urandom_range(99) < 80) begin
                push_req(REQ_ADD, fresh_mac(), fresh_ip(),
                         ($urandom_range(1) ? ST_DENY : ($urandom_range(1) ? ST_ALLOW : ST_OTHER)),
                         stamp(), 0);
                fill_n--;
            end else if ($urandom_range(1)) begin
                push_req(REQ_LMAC, known_mac(), 0, ST_ALLOW, 0, 0);
            end else begin
                push_req(REQ_LIP, 0, known_ip(), ST_ALLOW, 0, 0);
            end
        end
        push_req(REQ_LMAC, known_mac(), 0, ST_ALLOW, 0, 0);
        wait_drained();
        repeat (100) @(posedge aclk);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mlt_pkg.sv
design/mlt_ctrl.sv
design/mlt_dp.sv
design/mac_ip_learning_table_top.sv
tb/sv/mac_ip_learning_table_top_test.sv
